FILE: hw/rtl/cca_pkg.sv
package cca_pkg;

    localparam int AddrWidth = 5;
    localparam int DataWidth = 32;

    localparam logic [2:0] RegAlarmYear     = 3'd0;
    localparam logic [2:0] RegAlarmMonth    = 3'd1;
    localparam logic [2:0] RegAlarmDay      = 3'd2;
    localparam logic [2:0] RegAlarmHour     = 3'd3;
    localparam logic [2:0] RegAlarmMinute   = 3'd4;
    localparam logic [2:0] RegAlarmSecond   = 3'd5;
    localparam logic [2:0] RegAlarmEnable   = 3'd6;
    localparam logic [2:0] RegAlarmTimeOnly = 3'd7;

    localparam logic FuncTick = 1'b0;
    localparam logic FuncLoad = 1'b1;

    localparam logic [4:0] LenLong  = 5'd31;
    localparam logic [4:0] LenShort = 5'd30;
    localparam logic [4:0] LenLeap  = 5'd29;
    localparam logic [4:0] LenFeb   = 5'd28;
    localparam logic [5:0] SecMax   = 6'd59;
    localparam logic [4:0] HourMax  = 5'd23;
    localparam logic [6:0] YearMax  = 7'd99;
    localparam logic [5:0] UtcShift = 6'd8;
    localparam logic [5:0] DayHours = 6'd24;

    typedef struct packed {
        logic        func;
        logic [47:0] date_digits;
        logic [47:0] time_digits;
        logic        convert_from_utc;
        logic        add_catchup_second;
    } cmd_word_t;

    typedef struct packed {
        logic [6:0] year_now;
        logic [3:0] month_now;
        logic [4:0] day_now;
        logic [4:0] hour_now;
        logic [5:0] minute_now;
        logic [5:0] second_now;
        logic       alarm_hit;
    } res_word_t;

    typedef struct packed {
        logic [6:0] year;
        logic [3:0] month;
        logic [4:0] day;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
    } clock_t;

    typedef struct packed {
        logic [6:0] year;
        logic [3:0] month;
        logic [4:0] day;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
        logic       enable;
        logic       time_only;
    } alarm_cfg_t;

    // high*10 + low from the low nibbles of two ASCII bytes
    function automatic logic [7:0] digit_pair(input logic [15:0] pair);
        logic [7:0] hi;
        logic [7:0] lo;
        hi = {4'd0, pair[11:8]};
        lo = {4'd0, pair[3:0]};
        return (hi << 3) + (hi << 1) + lo;
    endfunction

    // 2000 + yoff: leap when yoff divisible by 4, except 2100
    function automatic logic is_leap(input logic [6:0] yoff);
        return (yoff[1:0] == 2'd0) && (yoff != 7'd100);
    endfunction

    function automatic clock_t next_day(input clock_t c);
        clock_t     r;
        logic [4:0] len;
        logic [5:0] d1;
        logic       known;
        r     = c;
        len   = LenLong;
        known = 1'b1;
        case (c.month)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = LenLong;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = LenShort;
            4'd2:    len = is_leap(c.year) ? LenLeap : LenFeb;
            default: known = 1'b0;
        endcase
        d1 = {1'b0, c.day} + 6'd1;
        if (known)
        begin
            if (d1 > {1'b0, len})
            begin
                d1 = d1 - {1'b0, len};
                if (c.month >= 4'd12)
                begin
                    r.month = 4'd1;
                    r.year  = (c.year >= YearMax) ? 7'd0 : c.year + 7'd1;
                end
                else
                begin
                    r.month = c.month + 4'd1;
                end
            end
            r.day = d1[4:0];
        end
        return r;
    endfunction

    function automatic clock_t next_second(input clock_t c);
        clock_t r;
        r = c;
        if (c.second < SecMax)
        begin
            r.second = c.second + 6'd1;
        end
        else if (c.minute < SecMax)
        begin
            r.second = 6'd0;
            r.minute = c.minute + 6'd1;
        end
        else if (c.hour < HourMax)
        begin
            r.second = 6'd0;
            r.minute = 6'd0;
            r.hour   = c.hour + 5'd1;
        end
        else
        begin
            r.second = 6'd0;
            r.minute = 6'd0;
            r.hour   = 5'd0;
            r        = next_day(r);
        end
        return r;
    endfunction

endpackage

FILE: hw/rtl/calendar_clock_with_alarm_unit.sv
// An accepted command word is held in the command register and its result
// word in the result register. Throughput: one word per cycle while the
// result is not stalled; the calendar update is one pass of logic between
// command and result registers. Reset (rst_n low, asynchronous): clock
// state, alarm registers and both valid flags clear to zero.
module calendar_clock_with_alarm_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cmd_valid,
    output logic                            cmd_stall,
    input  cca_pkg::cmd_word_t              cmd_word,
    output logic                            res_valid,
    input  logic                            res_stall,
    output cca_pkg::res_word_t              res_word,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [cca_pkg::AddrWidth-1:0]   paddr,
    input  logic [cca_pkg::DataWidth-1:0]   pwdata,
    output logic [cca_pkg::DataWidth-1:0]   prdata,
    output logic                            pready
);

    cca_pkg::alarm_cfg_t alarm_cfg;
    cca_pkg::cmd_word_t  cmd_reg;
    logic                cmd_valid_reg;
    cca_pkg::res_word_t  res_reg;
    logic                res_valid_reg;
    cca_pkg::clock_t     clock_reg;
    cca_pkg::clock_t     clock_next;
    logic                hit;
    logic                move;
    logic                take;

    cca_apb_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .alarm_cfg (alarm_cfg)
    );

    cca_update u_update (
        .cmd       (cmd_reg),
        .cur       (clock_reg),
        .alarm_cfg (alarm_cfg),
        .nxt       (clock_next),
        .hit       (hit)
    );

    assign move      = cmd_valid_reg && (!res_valid_reg || !res_stall);
    assign cmd_stall = cmd_valid_reg && !move;
    assign take      = cmd_valid && !cmd_stall;
    assign res_valid = res_valid_reg;
    assign res_word  = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
            clock_reg     <= '0;
        end
        else
        begin
            if (take)
            begin
                cmd_valid_reg <= 1'b1;
            end
            else if (move)
            begin
                cmd_valid_reg <= 1'b0;
            end
            if (move)
            begin
                res_valid_reg <= 1'b1;
                clock_reg     <= clock_next;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            cmd_reg <= cmd_word;
        end
        if (move)
        begin
            res_reg <= {clock_next.year, clock_next.month, clock_next.day,
                        clock_next.hour, clock_next.minute, clock_next.second, hit};
        end
    end

`ifndef NO_ASSERTIONS
    a_move_gives_word: assert property (@(posedge clk) disable iff (!rst_n)
        move |=> res_valid)
        else $error("result word missing after update");

    a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !move |=> $stable(clock_reg))
        else $error("clock state changed without a word");

    a_tick_second: assert property (@(posedge clk) disable iff (!rst_n)
        (move && (cmd_reg.func == cca_pkg::FuncTick) && (clock_reg.second < cca_pkg::SecMax))
        |=> (clock_reg.second == $past(clock_reg.second) + 6'd1))
        else $error("tick did not advance the second");
`endif

endmodule

FILE: hw/rtl/cca_apb_regs.sv
module cca_apb_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [cca_pkg::AddrWidth-1:0]   paddr,
    input  logic [cca_pkg::DataWidth-1:0]   pwdata,
    output logic [cca_pkg::DataWidth-1:0]   prdata,
    output logic                            pready,
    output cca_pkg::alarm_cfg_t             alarm_cfg
);

    cca_pkg::alarm_cfg_t cfg_reg;
    logic [2:0]          sel;
    logic                wr;

    assign pready    = 1'b1;
    assign sel       = paddr[4:2];
    assign wr        = psel && penable && pwrite;
    assign alarm_cfg = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (wr)
        begin
            unique case (sel)
                cca_pkg::RegAlarmYear:     cfg_reg.year      <= pwdata[6:0];
                cca_pkg::RegAlarmMonth:    cfg_reg.month     <= pwdata[3:0];
                cca_pkg::RegAlarmDay:      cfg_reg.day       <= pwdata[4:0];
                cca_pkg::RegAlarmHour:     cfg_reg.hour      <= pwdata[4:0];
                cca_pkg::RegAlarmMinute:   cfg_reg.minute    <= pwdata[5:0];
                cca_pkg::RegAlarmSecond:   cfg_reg.second    <= pwdata[5:0];
                cca_pkg::RegAlarmEnable:   cfg_reg.enable    <= pwdata[0];
                cca_pkg::RegAlarmTimeOnly: cfg_reg.time_only <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (sel)
            cca_pkg::RegAlarmYear:     prdata = {25'd0, cfg_reg.year};
            cca_pkg::RegAlarmMonth:    prdata = {28'd0, cfg_reg.month};
            cca_pkg::RegAlarmDay:      prdata = {27'd0, cfg_reg.day};
            cca_pkg::RegAlarmHour:     prdata = {27'd0, cfg_reg.hour};
            cca_pkg::RegAlarmMinute:   prdata = {26'd0, cfg_reg.minute};
            cca_pkg::RegAlarmSecond:   prdata = {26'd0, cfg_reg.second};
            cca_pkg::RegAlarmEnable:   prdata = {31'd0, cfg_reg.enable};
            cca_pkg::RegAlarmTimeOnly: prdata = {31'd0, cfg_reg.time_only};
            default:                   prdata = '0;
        endcase
    end

endmodule

FILE: hw/rtl/cca_update.sv
module cca_update (
    input  cca_pkg::cmd_word_t  cmd,
    input  cca_pkg::clock_t     cur,
    input  cca_pkg::alarm_cfg_t alarm_cfg,
    output cca_pkg::clock_t     nxt,
    output logic                hit
);

    cca_pkg::clock_t loaded;
    cca_pkg::clock_t shifted;
    logic [7:0]      dd;
    logic [7:0]      mo;
    logic [7:0]      yy;
    logic [7:0]      hh;
    logic [7:0]      mi;
    logic [7:0]      ss;
    logic [5:0]      utc_hour;
    logic            time_eq;
    logic            date_eq;

    assign dd = cca_pkg::digit_pair(cmd.date_digits[47:32]);
    assign mo = cca_pkg::digit_pair(cmd.date_digits[31:16]);
    assign yy = cca_pkg::digit_pair(cmd.date_digits[15:0]);
    assign hh = cca_pkg::digit_pair(cmd.time_digits[47:32]);
    assign mi = cca_pkg::digit_pair(cmd.time_digits[31:16]);
    assign ss = cca_pkg::digit_pair(cmd.time_digits[15:0]);

    always_comb
    begin
        loaded.day    = dd[4:0];
        loaded.month  = mo[3:0];
        loaded.year   = yy[6:0];
        loaded.hour   = hh[4:0];
        loaded.minute = mi[5:0];
        loaded.second = ss[5:0];
        utc_hour      = {1'b0, loaded.hour} + cca_pkg::UtcShift;
        shifted       = loaded;
        if (cmd.convert_from_utc)
        begin
            if (utc_hour >= cca_pkg::DayHours)
            begin
                shifted.hour = 5'(utc_hour - cca_pkg::DayHours);
                shifted      = cca_pkg::next_day(shifted);
            end
            else
            begin
                shifted.hour = utc_hour[4:0];
            end
        end
        if (cmd.func == cca_pkg::FuncLoad)
        begin
            nxt = cmd.add_catchup_second ? cca_pkg::next_second(shifted) : shifted;
        end
        else
        begin
            nxt = cca_pkg::next_second(cur);
        end
    end

    assign time_eq = (alarm_cfg.hour == nxt.hour) && (alarm_cfg.minute == nxt.minute)
                     && (alarm_cfg.second == nxt.second);
    assign date_eq = (alarm_cfg.year == nxt.year) && (alarm_cfg.month == nxt.month)
                     && (alarm_cfg.day == nxt.day);
    assign hit     = alarm_cfg.enable && time_eq && (alarm_cfg.time_only || date_eq);

endmodule
